[rtl/core/hrpl_pkg.sv]
// ----------------------------------------------------------------------------
// hrpl_pkg: shared definitions for the hex record page loader
// Event codes, field widths and the hex digit decoder used by the parser.
// ----------------------------------------------------------------------------
package hrpl_pkg;

  localparam int DefaultPageBytes = 256;

  localparam int CharWidth  = 8;
  localparam int EventWidth = 3;
  localparam int AddrWidth  = 32;
  localparam int DataWidth  = 8;
  localparam int PageWidth  = 24;

  typedef logic [EventWidth-1:0] event_t;

  localparam event_t EV_NONE      = 3'd0;
  localparam event_t EV_DATA      = 3'd1;
  localparam event_t EV_EOF       = 3'd2;
  localparam event_t EV_BAD_MARK  = 3'd3;
  localparam event_t EV_CSUM_FAIL = 3'd4;

  localparam logic [7:0] CHAR_MARK = 8'h3A;

  localparam logic [7:0] KIND_DATA    = 8'h00;
  localparam logic [7:0] KIND_EOF     = 8'h01;
  localparam logic [7:0] KIND_SEGMENT = 8'h02;
  localparam logic [7:0] KIND_LINEAR  = 8'h04;

  // Value of a hex digit; any other character stands for its own code.
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c;
    end
    return v;
  endfunction

endpackage

[rtl/core/hrpl_char_if.sv]
// ----------------------------------------------------------------------------
// hrpl_char_if: character channel
// Carries one received character per transaction under valid and ready.
// ----------------------------------------------------------------------------
interface hrpl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

[rtl/core/hrpl_res_if.sv]
// ----------------------------------------------------------------------------
// hrpl_res_if: result channel
// Carries one parse result per transaction under valid and ready.
// ----------------------------------------------------------------------------
interface hrpl_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] byte_addr;
  logic [7:0]  byte_data;
  logic        commit;
  logic [23:0] commit_page;

  modport source (output valid, output event_res, output byte_addr, output byte_data,
                  output commit, output commit_page, input ready);
  modport sink   (input valid, input event_res, input byte_addr, input byte_data,
                  input commit, input commit_page, output ready);
endinterface

[rtl/core/hrpl_in_reg.sv]
// ----------------------------------------------------------------------------
// hrpl_in_reg: input register stage
// Registers each incoming character and passes it on when the parser can take it.
// ----------------------------------------------------------------------------
module hrpl_in_reg
  import hrpl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hrpl_char_if.sink   up,
  hrpl_char_if.source down
);

  logic                 held_valid;
  logic [CharWidth-1:0] held_char;

  assign up.ready     = !held_valid || down.ready;
  assign down.valid   = held_valid;
  assign down.char_in = held_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (up.ready) begin
      held_valid <= up.valid;
    end
    if (up.valid && up.ready) begin
      held_char <= up.char_in;
    end
  end

endmodule

[rtl/core/hrpl_parser.sv]
// ----------------------------------------------------------------------------
// hrpl_parser: record parser and result register
// Walks the record fields one character at a time and registers one result per character.
// ----------------------------------------------------------------------------
module hrpl_parser
  import hrpl_pkg::*;
#(
  parameter int PAGE_BYTES = DefaultPageBytes
) (
  input  logic clk,
  input  logic rst,
  hrpl_char_if.sink  chars,
  hrpl_res_if.source results
);

  localparam int PageShift = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    PH_MARK, PH_LEN, PH_OFF, PH_TYPE, PH_DATA, PH_CSUM, PH_END, PH_HALT
  } phase_t;

  phase_t                phase;
  logic                  nibble_pending;
  logic [3:0]            high_nibble;
  logic [7:0]            field_count;
  logic [7:0]            record_length;
  logic [7:0]            running_sum;
  logic [7:0]            record_kind;
  logic [15:0]           load_offset;
  logic [AddrWidth-1:0]  base_address;
  logic [AddrWidth-1:0]  next_address;
  logic [AddrWidth-1:0]  last_address;
  logic                  page_dirty;

  logic                  res_valid;
  event_t                res_event;
  logic [AddrWidth-1:0]  res_addr;
  logic [DataWidth-1:0]  res_data;
  logic                  res_commit;
  logic [PageWidth-1:0]  res_page;

  logic                  take;
  logic [7:0]            digit;
  logic [7:0]            byte_val;
  logic [7:0]            sum_next;
  logic [7:0]            count_inc;
  logic [PageWidth-1:0]  last_page;
  logic                  page_change;

  function automatic logic [PageWidth-1:0] page_of(input logic [AddrWidth-1:0] a);
    logic [AddrWidth-1:0] s;
    s = a >> PageShift;
    return s[PageWidth-1:0];
  endfunction

  assign chars.ready = !res_valid || results.ready;
  assign take        = chars.valid && chars.ready;

  assign digit       = hex_digit(chars.char_in);
  assign byte_val    = {high_nibble, 4'b0000} + digit;
  assign sum_next    = running_sum + byte_val;
  assign count_inc   = field_count + 8'd1;
  assign last_page   = page_of(last_address);
  assign page_change = page_dirty && (page_of(next_address) != last_page);

  assign results.valid       = res_valid;
  assign results.event_res   = res_event;
  assign results.byte_addr   = res_addr;
  assign results.byte_data   = res_data;
  assign results.commit      = res_commit;
  assign results.commit_page = res_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MARK;
      nibble_pending <= 1'b0;
      field_count    <= 8'd0;
      base_address   <= '0;
      page_dirty     <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (take) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end

      if (take) begin
        res_event  <= EV_NONE;
        res_addr   <= '0;
        res_data   <= '0;
        res_commit <= 1'b0;
        res_page   <= '0;

        unique case (phase)
          PH_MARK: begin
            if (chars.char_in == CHAR_MARK) begin
              phase          <= PH_LEN;
              nibble_pending <= 1'b0;
              running_sum    <= 8'd0;
              field_count    <= 8'd0;
            end else begin
              res_event <= EV_BAD_MARK;
              phase     <= PH_HALT;
            end
          end

          PH_LEN, PH_OFF, PH_TYPE, PH_DATA, PH_CSUM: begin
            if (!nibble_pending) begin
              high_nibble    <= digit[3:0];
              nibble_pending <= 1'b1;
            end else begin
              nibble_pending <= 1'b0;
              case (phase)
                PH_LEN: begin
                  record_length <= byte_val;
                  running_sum   <= sum_next;
                  field_count   <= 8'd0;
                  phase         <= PH_OFF;
                end
                PH_OFF: begin
                  running_sum <= sum_next;
                  if (field_count == 8'd0) begin
                    load_offset <= {byte_val, 8'h00};
                    field_count <= 8'd1;
                  end else begin
                    load_offset <= {load_offset[15:8], byte_val};
                    field_count <= 8'd0;
                    phase       <= PH_TYPE;
                  end
                end
                PH_TYPE: begin
                  record_kind <= byte_val;
                  running_sum <= sum_next;
                  if (byte_val == KIND_EOF) begin
                    // End of file flushes the page still being gathered.
                    res_event  <= EV_EOF;
                    res_commit <= page_dirty;
                    res_page   <= page_dirty ? last_page : '0;
                    page_dirty <= 1'b0;
                    phase      <= PH_HALT;
                  end else begin
                    next_address <= base_address + {16'h0000, load_offset};
                    field_count  <= 8'd0;
                    phase        <= (record_length != 8'd0) ? PH_DATA : PH_CSUM;
                  end
                end
                PH_DATA: begin
                  running_sum <= sum_next;
                  if (record_kind == KIND_DATA) begin
                    // A byte outside the buffered page commits that page first.
                    if (page_change) begin
                      res_commit <= 1'b1;
                      res_page   <= last_page;
                    end
                    page_dirty   <= 1'b1;
                    last_address <= next_address;
                    next_address <= next_address + 32'd1;
                    res_event    <= EV_DATA;
                    res_addr     <= next_address;
                    res_data     <= byte_val;
                  end else if (record_kind == KIND_SEGMENT) begin
                    if (field_count == 8'd0) begin
                      base_address <= {12'h000, byte_val, 12'h000};
                    end else if (field_count == 8'd1) begin
                      base_address <= base_address | {20'h00000, byte_val, 4'h0};
                    end
                  end else if (record_kind == KIND_LINEAR) begin
                    if (field_count == 8'd0) begin
                      base_address <= {byte_val, 24'h000000};
                    end else if (field_count == 8'd1) begin
                      base_address <= base_address | {8'h00, byte_val, 16'h0000};
                    end
                  end
                  if (count_inc >= record_length) begin
                    field_count <= 8'd0;
                    phase       <= PH_CSUM;
                  end else begin
                    field_count <= count_inc;
                  end
                end
                PH_CSUM: begin
                  if (sum_next != 8'd0) begin
                    res_event <= EV_CSUM_FAIL;
                    phase     <= PH_HALT;
                  end else begin
                    field_count <= 8'd0;
                    phase       <= PH_END;
                  end
                end
                default: begin
                end
              endcase
            end
          end

          PH_END: begin
            if (field_count == 8'd0) begin
              field_count <= 8'd1;
            end else begin
              field_count <= 8'd0;
              phase       <= PH_MARK;
            end
          end

          PH_HALT: begin
          end

          default: begin
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/hex_record_page_loader.sv]
// ----------------------------------------------------------------------------
// hex_record_page_loader: hex record parser feeding a paged flash writer
// Parses hex records one character per transaction and reports data bytes,
// their absolute addresses and the moments at which a page must be written.
// ----------------------------------------------------------------------------
// The chars channel takes one received character per transaction. The
// results channel returns exactly one result per character: an event code,
// the address and value of a data byte, and a commit flag with the index of
// the page that is due for programming.
// A character passes through an input register and is then parsed into the
// result register, from which its result is offered on the results channel.
// While the receiver of results keeps ready high, both stages move every
// cycle, so one character per cycle is sustained; the parser state update
// between the two registers is the only work on that path.
// When the receiver of results stalls, the result register holds its
// transaction and the input register fills; a character is still taken
// while a finished result waits, and ready falls only when both are full.
// Reset clears both stages and returns the parser to waiting for a record
// mark with no page buffered and a zero base address. A bad mark, a failed
// checksum or the end-of-file record halts parsing until the next reset;
// later characters are still accepted and each gives an empty result.
// ----------------------------------------------------------------------------
module hex_record_page_loader
  import hrpl_pkg::*;
#(
  parameter int PAGE_BYTES = DefaultPageBytes
) (
  input  logic clk,
  input  logic rst,
  hrpl_char_if.sink  chars,
  hrpl_res_if.source results
);

  // Registered character handed from the input stage to the parser.
  hrpl_char_if held ();

  hrpl_in_reg u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .up   (chars),
    .down (held)
  );

  // Parser state and the result register share one stage.
  hrpl_parser #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .chars   (held),
    .results (results)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hex record page loader
// Feeds well-formed hex files with random content, mixed with noisy encodings
// and stray line ends, into the character channel. Every result is checked
// against an in-bench model of the parser. The run closes with one halting
// condition, chosen at random, followed by characters that must give empty
// results.
// ----------------------------------------------------------------------------
module tb_top;
  import hrpl_pkg::*;

  // The page size is pinned here so that the model and the block agree.
  localparam int PageBytes = DefaultPageBytes;

  // Record types that the block only sums; they are not in the package.
  localparam logic [7:0] KIND_START_SEG = 8'h03;
  localparam logic [7:0] KIND_START_LIN = 8'h05;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Stimulus size and the points at which the two pressure cases occur.
  localparam int RandomChars = 1400;
  localparam int DrainAt     = 800;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 120;
  localparam int TailChars   = 16;
  localparam int SettleTime  = 10;
  localparam int CycleLimit  = 200000;

  typedef enum logic [2:0] {
    WAIT_MARK, GET_LEN, GET_OFFSET, GET_KIND, GET_DATA, GET_SUM, SKIP_EOL
  } parse_phase_t;

  typedef enum int {END_BY_EOF, END_BY_BAD_MARK, END_BY_BAD_SUM} ending_t;

  typedef struct packed {
    event_t      ev;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        commit;
    logic [23:0] page;
  } load_result_t;

  logic clk;
  logic rst = 1'b1;

  hrpl_char_if chars_if ();
  hrpl_res_if  res_if ();

  hex_record_page_loader #(
    .PAGE_BYTES(PageBytes)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  // Characters waiting to be offered, and the results that the accepted
  // characters are expected to produce, oldest first.
  logic [7:0]   char_stream[$];
  load_result_t load_expect[$];

  int chars_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  // --------------------------------------------------------------------------
  // Parser model. Its state mirrors the block's and is advanced once for
  // every character that the block accepts.
  // --------------------------------------------------------------------------
  parse_phase_t ph         = WAIT_MARK;
  bit           half_seen  = 1'b0;
  logic [7:0]   hi_digit   = '0;
  logic [7:0]   field_idx  = '0;
  logic [7:0]   rec_len    = '0;
  logic [7:0]   sum_acc    = '0;
  logic [7:0]   rec_kind   = '0;
  logic [15:0]  rec_offset = '0;
  logic [31:0]  base_addr  = '0;
  logic [31:0]  write_addr = '0;
  logic [31:0]  prev_addr  = '0;
  bit           page_open  = 1'b0;
  bit           stopped    = 1'b0;

  // Hex digits decode to their value; anything else stands for its own code.
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return c - "0";
    end else if (c >= "a" && c <= "f") begin
      return c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      return c - "A" + 8'd10;
    end
    return c;
  endfunction

  function automatic logic [23:0] page_index(input logic [31:0] a);
    logic [31:0] q;
    q = a / 32'(PageBytes);
    return q[23:0];
  endfunction

  function automatic load_result_t parse_char(input logic [7:0] c);
    load_result_t r;
    logic [7:0]   b;
    logic [7:0]   total;
    r = '0;
    if (stopped) begin
      return r;
    end
    if (ph == SKIP_EOL) begin
      // Both line-end characters are dropped, whatever they are.
      if (field_idx == 0) begin
        field_idx = 1;
      end else begin
        field_idx = 0;
        ph = WAIT_MARK;
      end
    end else if (ph == WAIT_MARK) begin
      if (c == CHAR_MARK) begin
        ph = GET_LEN;
        half_seen = 1'b0;
        sum_acc = '0;
        field_idx = '0;
      end else begin
        r.ev = EV_BAD_MARK;
        stopped = 1'b1;
      end
    end else if (!half_seen) begin
      hi_digit = nibble_of(c);
      half_seen = 1'b1;
    end else begin
      half_seen = 1'b0;
      b = {hi_digit[3:0], 4'h0} + nibble_of(c);
      case (ph)
        GET_LEN: begin
          rec_len = b;
          sum_acc += b;
          field_idx = '0;
          ph = GET_OFFSET;
        end
        GET_OFFSET: begin
          sum_acc += b;
          if (field_idx == 0) begin
            rec_offset = {b, 8'h00};
            field_idx = 1;
          end else begin
            rec_offset[7:0] = b;
            field_idx = 0;
            ph = GET_KIND;
          end
        end
        GET_KIND: begin
          rec_kind = b;
          sum_acc += b;
          if (b == KIND_EOF) begin
            // End of file flushes the buffered page and needs no checksum.
            r.ev = EV_EOF;
            if (page_open) begin
              r.commit = 1'b1;
              r.page = page_index(prev_addr);
            end
            page_open = 1'b0;
            stopped = 1'b1;
          end else begin
            write_addr = base_addr + {16'h0000, rec_offset};
            field_idx = '0;
            ph = (rec_len != 0) ? GET_DATA : GET_SUM;
          end
        end
        GET_DATA: begin
          sum_acc += b;
          if (rec_kind == KIND_DATA) begin
            // A byte outside the buffered page sends that page off first.
            if (page_open && page_index(write_addr) != page_index(prev_addr)) begin
              r.commit = 1'b1;
              r.page = page_index(prev_addr);
            end
            page_open = 1'b1;
            prev_addr = write_addr;
            r.ev = EV_DATA;
            r.addr = write_addr;
            r.data = b;
            write_addr = write_addr + 32'd1;
          end else if (rec_kind == KIND_SEGMENT) begin
            if (field_idx == 0) begin
              base_addr = {12'h000, b, 12'h000};
            end else if (field_idx == 1) begin
              base_addr |= {20'h00000, b, 4'h0};
            end
          end else if (rec_kind == KIND_LINEAR) begin
            if (field_idx == 0) begin
              base_addr = {b, 24'h000000};
            end else if (field_idx == 1) begin
              base_addr |= {8'h00, b, 16'h0000};
            end
          end
          field_idx += 1;
          if (field_idx >= rec_len) begin
            field_idx = '0;
            ph = GET_SUM;
          end
        end
        GET_SUM: begin
          total = sum_acc + b;
          if (total != 0) begin
            r.ev = EV_CSUM_FAIL;
            stopped = 1'b1;
          end else begin
            field_idx = '0;
            ph = SKIP_EOL;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation. Records are built byte by byte; a byte is either
  // written as two hex digits of random case or, in noisy records, as two
  // arbitrary characters whose decoded value then becomes the byte.
  // --------------------------------------------------------------------------
  logic [15:0] gen_next_off = '0;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) begin
      return 8'h30 + 8'(n);
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic emit_byte(input logic [7:0] want, input bit raw, input bit no_eof,
                           inout logic [7:0] csum, output logic [7:0] got);
    logic [7:0] c1;
    logic [7:0] c2;
    if (raw) begin
      do begin
        c1 = 8'($urandom);
        c2 = 8'($urandom);
        got = (nibble_of(c1) << 4) + nibble_of(c2);
      end while (no_eof && got == KIND_EOF);
    end else begin
      c1 = hex_char(want[7:4]);
      c2 = hex_char(want[3:0]);
      got = want;
    end
    char_stream.push_back(c1);
    char_stream.push_back(c2);
    csum += got;
  endtask

  // fill below zero draws the data bytes at random; otherwise every data byte
  // takes that value. A wild record may carry non-hex encodings and odd line
  // ends; a record with sum_ok low closes with a wrong checksum.
  task automatic emit_record(input logic [7:0] kind, input int len, input logic [15:0] off,
                             input int fill, input bit sum_ok, input bit wild);
    logic [7:0] sum;
    logic [7:0] got;
    logic [7:0] count;
    logic [7:0] val;
    sum = '0;
    char_stream.push_back(CHAR_MARK);
    emit_byte(8'(len), wild && $urandom_range(0, 39) == 0, 1'b0, sum, count);
    emit_byte(off[15:8], wild && $urandom_range(0, 15) == 0, 1'b0, sum, got);
    emit_byte(off[7:0], wild && $urandom_range(0, 15) == 0, 1'b0, sum, got);
    emit_byte(kind, wild && kind != KIND_EOF && $urandom_range(0, 29) == 0, 1'b1, sum, got);
    for (int i = 0; i < int'(count); i++) begin
      if (fill >= 0) begin
        val = 8'(fill);
      end else if ((kind == KIND_SEGMENT || kind == KIND_LINEAR) && $urandom_range(0, 2) == 0) begin
        val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        val = 8'($urandom);
      end
      emit_byte(val, wild && $urandom_range(0, 7) == 0, 1'b0, sum, got);
    end
    val = 8'h00 - sum;
    if (!sum_ok) begin
      val += 8'($urandom_range(1, 255));
    end
    emit_byte(val, 1'b0, 1'b0, sum, got);
    if (wild && $urandom_range(0, 9) == 0) begin
      char_stream.push_back(8'($urandom));
      char_stream.push_back(8'($urandom));
    end else begin
      char_stream.push_back(CHAR_CR);
      char_stream.push_back(CHAR_LF);
    end
    if (kind == KIND_DATA) begin
      gen_next_off = off + 16'(count);
    end
  endtask

  // Idle gap before the next transaction, drawn at random as a rule, with runs
  // of back-to-back transactions now and then.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(20, 60);
    end
    return $urandom_range(0, 4);
  endfunction

  // --------------------------------------------------------------------------
  // Clock and initial levels. Every input of the block is known from time 0.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    chars_if.valid = 1'b0;
    chars_if.char_in = '0;
    res_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Character driver. A new character is offered once the previous
  // transaction has completed and its idle gap has run out. The model is
  // stepped at the very edge at which the block takes a character. Once, the
  // driver stops offering until every outstanding result has come back.
  // --------------------------------------------------------------------------
  int send_gap   = 0;
  int send_quiet = 0;
  bit draining   = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
      chars_if.char_in <= '0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        load_expect.push_back(parse_char(chars_if.char_in));
        chars_sent++;
        if (chars_sent == DrainAt) begin
          draining = 1'b1;
        end
      end
      if (draining && load_expect.size() == 0) begin
        draining = 1'b0;
      end
      if (!chars_if.valid || chars_if.ready) begin
        if (send_gap > 0 || draining || char_stream.size() == 0) begin
          chars_if.valid <= 1'b0;
          if (send_gap > 0) begin
            send_gap--;
          end
        end else begin
          chars_if.valid <= 1'b1;
          chars_if.char_in <= char_stream.pop_front();
          send_gap = draw_wait(send_quiet);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each result transaction is compared field by field with
  // the oldest expectation. Once, ready is held low for a long stretch while
  // the driver keeps offering, so that both stages of the block fill and the
  // character channel stalls.
  // --------------------------------------------------------------------------
  int           take_gap   = 0;
  int           take_quiet = 0;
  int           hold_left  = 0;
  bit           hold_done  = 1'b0;
  load_result_t due;

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (load_expect.size() == 0) begin
          $error("unexpected result transaction: event_res %0d", res_if.event_res);
          mismatches++;
        end else begin
          due = load_expect.pop_front();
          if (res_if.event_res !== due.ev) begin
            $error("event_res: expected %0d, got %0d", due.ev, res_if.event_res);
            mismatches++;
          end
          if (res_if.byte_addr !== due.addr) begin
            $error("byte_addr: expected %h, got %h", due.addr, res_if.byte_addr);
            mismatches++;
          end
          if (res_if.byte_data !== due.data) begin
            $error("byte_data: expected %h, got %h", due.data, res_if.byte_data);
            mismatches++;
          end
          if (res_if.commit !== due.commit) begin
            $error("commit: expected %0d, got %0d", due.commit, res_if.commit);
            mismatches++;
          end
          if (res_if.commit_page !== due.page) begin
            $error("commit_page: expected %h, got %h", due.page, res_if.commit_page);
            mismatches++;
          end
        end
        take_gap = draw_wait(take_quiet);
      end
      if (!hold_done && results_seen >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (take_gap > 0) begin
        res_if.ready <= 1'b0;
        take_gap--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence. The block halts for good on a bad mark, a failed checksum
  // or the end-of-file record, and reset comes only once, so the whole body
  // of the run is well-formed records and one halting condition closes it.
  // --------------------------------------------------------------------------
  initial begin
    int         total_chars;
    int         pick;
    int         len;
    logic [7:0] kind;
    logic [7:0] stray;
    ending_t    ending;

    // Directed opening: a linear base of FFFF0000 followed by a data record
    // at offset FFFF, so that the second byte wraps the address to zero and
    // the page holding the top of memory is committed.
    emit_record(KIND_LINEAR, 2, 16'h0000, 8'hFF, 1'b1, 1'b0);
    emit_record(KIND_DATA, 2, 16'hFFFF, -1, 1'b1, 1'b0);

    // Random body. Data records dominate; base records steer the address
    // space, including its extremes, and the summed-only types appear too.
    while (char_stream.size() < RandomChars) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        kind = KIND_DATA;
      end else if (pick < 14) begin
        kind = KIND_SEGMENT;
      end else if (pick < 16) begin
        kind = KIND_LINEAR;
      end else if (pick == 16) begin
        kind = KIND_START_SEG;
      end else if (pick == 17) begin
        kind = KIND_START_LIN;
      end else begin
        kind = 8'($urandom_range(6, 255));
      end

      if (kind == KIND_DATA) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          len = 0;
        end else if (pick < 92) begin
          len = $urandom_range(1, 16);
        end else if (pick < 99) begin
          len = $urandom_range(17, 64);
        end else begin
          len = 255;
        end
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
          emit_record(kind, len, gen_next_off, -1, 1'b1, 1'b1);
        end else if (pick == 2) begin
          emit_record(kind, len, 16'($urandom), -1, 1'b1, 1'b1);
        end else begin
          emit_record(kind, len, {8'hFF, 8'($urandom)}, -1, 1'b1, 1'b1);
        end
      end else if (kind == KIND_SEGMENT || kind == KIND_LINEAR) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 2;
        emit_record(kind, len, 16'($urandom), -1, 1'b1, 1'b1);
      end else begin
        emit_record(kind, $urandom_range(0, 8), 16'($urandom), -1, 1'b1, 1'b1);
      end
    end

    // The closing condition; after it every character must give an empty
    // result.
    ending = ending_t'($urandom_range(0, 2));
    case (ending)
      END_BY_EOF: begin
        emit_record(KIND_EOF, $urandom_range(0, 4), 16'($urandom), -1, 1'b1, 1'b0);
      end
      END_BY_BAD_MARK: begin
        do begin
          stray = 8'($urandom);
        end while (stray == CHAR_MARK);
        char_stream.push_back(stray);
      end
      default: begin
        emit_record(KIND_DATA, $urandom_range(1, 8), gen_next_off, -1, 1'b0, 1'b0);
      end
    endcase
    for (int i = 0; i < TailChars; i++) begin
      char_stream.push_back(8'($urandom));
    end
    total_chars = char_stream.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every character to be taken and every result to come back,
    // then let the pipeline settle so that any stray result shows.
    while (chars_sent < total_chars || load_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleTime) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[hex_record_page_loader.f]
rtl/core/hrpl_pkg.sv
rtl/core/hrpl_char_if.sv
rtl/core/hrpl_res_if.sv
rtl/core/hrpl_in_reg.sv
rtl/core/hrpl_parser.sv
rtl/core/hex_record_page_loader.sv
verif/tb_top.sv
